// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int WORD_W    = 32;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Broadcast command to every cell; at most one bit is set in a cycle.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_cmd_t;

endpackage

// ===== rtl/deq_cell.sv =====
module deq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic                         clk,
  input  deq_pkg::cell_cmd_t           cmd,
  input  logic [CW-1:0]                count,
  input  logic [CW-1:0]                count_m1,
  input  logic [deq_pkg::WORD_W-1:0]   push_value,
  input  logic [deq_pkg::WORD_W-1:0]   left_data,
  input  logic [deq_pkg::WORD_W-1:0]   right_data,
  input  logic [deq_pkg::WORD_W-1:0]   right_ret,
  output logic [deq_pkg::WORD_W-1:0]   data,
  output logic [deq_pkg::WORD_W-1:0]   ret
);

  localparam logic [CW-1:0] MY_POS = CW'(IDX);

  logic [deq_pkg::WORD_W-1:0] data_r, data_nxt;
  logic [deq_pkg::WORD_W-1:0] ret_r, ret_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.push_front) begin
      data_nxt = left_data;
    end else if (cmd.pop_front) begin
      data_nxt = right_data;
    end else if (cmd.push_back && (count == MY_POS)) begin
      data_nxt = push_value;
    end
  end

  // Return lane: the tail cell drops its word in, then it walks toward cell 0.
  always_comb begin
    if (cmd.pop_back && (count_m1 == MY_POS)) begin
      ret_nxt = data_r;
    end else begin
      ret_nxt = right_ret;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    ret_r  <= ret_nxt;
  end

  assign data = data_r;
  assign ret  = ret_r;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// Channel | Dir | Ports                          | Transfer carries
// in      | in  | in_tvalid/in_tready            | tuser: operation; tdata: push_value
// out     | out | out_tvalid/out_tready          | tuser: status; tdata: popped_value, occupancy
//
// For push front, push back, pop front and refused operations the result sits
// in the output register the cycle after the transfer.
// Pop back holds the input off while the tail word walks down the return lane
// of the cell row one cell per cycle to reach cell 0.
// Reset (rst_n low, synchronous) empties the queue; cell contents are kept.
// A new item is taken while the output register drains; out_tready low holds
// the result and, once the output register is full, stalls the input.
module double_ended_queue_core #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((deq_pkg::WORD_W + CW + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [deq_pkg::WORD_W-1:0]    in_tdata,   // [31:0] push_value
  input  logic [deq_pkg::OP_W-1:0]      in_tuser,   // [1:0] operation
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata,  // [31:0] popped_value, then occupancy
  output logic [deq_pkg::STAT_W-1:0]    out_tuser   // [1:0] status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BACK = 1'b1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Cell row: cell 0 holds the front word, cell count-1 the back word.
  logic [deq_pkg::WORD_W-1:0] cell_data [DEPTH];
  logic [deq_pkg::WORD_W-1:0] cell_ret  [DEPTH];

  logic                        state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               wait_r, wait_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [deq_pkg::WORD_W-1:0]  out_pop_r, out_pop_nxt;
  logic [deq_pkg::STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [CW-1:0]               out_occ_r, out_occ_nxt;

  logic                        accept;
  logic                        is_push;
  logic                        full;
  logic                        empty;
  logic [deq_pkg::STAT_W-1:0]  status;
  logic                        do_op;
  logic [CW-1:0]               count_m1;
  deq_pkg::cell_cmd_t          cmd;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign is_push   = in_tuser inside {deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK};
  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign count_m1  = count_r - CW'(1);

  // Refuse a push into a full queue and a pop from an empty one.
  always_comb begin
    if (is_push && full) begin
      status = deq_pkg::STAT_FULL;
    end else if (!is_push && empty) begin
      status = deq_pkg::STAT_EMPTY;
    end else begin
      status = deq_pkg::STAT_OK;
    end
  end

  assign do_op          = accept && (status == deq_pkg::STAT_OK);
  assign cmd.push_front = do_op && (in_tuser == deq_pkg::OP_PUSH_FRONT);
  assign cmd.push_back  = do_op && (in_tuser == deq_pkg::OP_PUSH_BACK);
  assign cmd.pop_front  = do_op && (in_tuser == deq_pkg::OP_POP_FRONT);
  assign cmd.pop_back   = do_op && (in_tuser == deq_pkg::OP_POP_BACK);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [deq_pkg::WORD_W-1:0] left_d, right_d, right_r;
    if (g == 0) begin : g_first
      assign left_d = in_tdata;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = cell_data[g];
      assign right_r = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
      assign right_r = cell_ret[g+1];
    end
    deq_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .count_m1   (count_m1),
      .push_value (in_tdata),
      .left_data  (left_d),
      .right_data (right_d),
      .right_ret  (right_r),
      .data       (cell_data[g]),
      .ret        (cell_ret[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pop_nxt   = out_pop_r;
    out_stat_nxt  = out_stat_r;
    out_occ_nxt   = out_occ_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (do_op) begin
            count_nxt = is_push ? count_r + CW'(1) : count_m1;
          end
          if (cmd.pop_back) begin
            // Wait for the tail word to reach cell 0 of the return lane.
            state_nxt = ST_BACK;
            wait_nxt  = count_m1;
          end else begin
            out_valid_nxt = 1'b1;
            out_pop_nxt   = cmd.pop_front ? cell_data[0] : '0;
            out_stat_nxt  = status;
            out_occ_nxt   = do_op ? (is_push ? count_r + CW'(1) : count_m1) : count_r;
          end
        end
      end
      ST_BACK: begin
        if (wait_r == '0) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_pop_nxt   = cell_ret[0];
          out_stat_nxt  = deq_pkg::STAT_OK;
          out_occ_nxt   = count_r;
        end else begin
          wait_nxt = wait_r - CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pop_r  <= out_pop_nxt;
    out_stat_r <= out_stat_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = OUT_W'({out_occ_r, out_pop_r});

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count above depth");

  a_back_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BACK) |-> (wait_r <= count_r))
    else $error("return lane wait exceeds queue count");

  a_refuse_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status != deq_pkg::STAT_OK)) |=> (count_r == $past(count_r)))
    else $error("refused operation changed the count");

  a_back_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BACK && wait_r == '0) |=> (out_tvalid && state_r == ST_IDLE))
    else $error("pop back result not delivered");

endmodule
